FILE: hdl/point_in_polygon_test_defines.svh
// ============================================================================
// Assertion macros for the point-in-polygon test block
// Shared assertion forms, clocked on i_clk and disabled while i_rst_n is low.
// ============================================================================
`ifndef POINT_IN_POLYGON_TEST_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_DEFINES_SVH

// Same-cycle implication: when the antecedent holds, the consequent holds too.
`define PIP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication: when the antecedent holds, the consequent follows.
`define PIP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

FILE: hdl/pip_pkg.sv
// ============================================================================
// Point-in-polygon package
// Operation codes and the command and status groups between the controller
// and the datapath.
// ============================================================================
package pip_pkg;

    // Operation codes carried on the input operation field.
    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic append;       // store the accepted vertex
        logic query_start;  // latch the query point and clear the parity
        logic rd_en;        // read one vertex from the store
        logic rd_first;     // this read fetches the closing vertex
        logic load_out;     // move the finished answer into the output register
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic busy;         // edge pipeline still holds work
        logic out_free;     // output register can take a new result
        logic empty;        // no vertex stored
    } t_dp_sts;

endpackage

FILE: hdl/pip_ctrl.sv
// ============================================================================
// Point-in-polygon controller
// Sequences one query: fetches the closing vertex, walks the store one
// vertex per cycle, waits for the edge pipeline to drain and posts the result.
// ============================================================================
module pip_ctrl import pip_pkg::*; #(
    parameter int IW = 3
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_operation,
    input  t_dp_sts       i_sts,
    input  logic [IW-1:0] i_last,
    output t_dp_cmd       o_cmd,
    output logic [IW-1:0] o_rd_addr,
    output logic          o_busy
);

    typedef enum logic [2:0] {
        S_IDLE  = 3'b001,
        S_WALK  = 3'b010,
        S_DRAIN = 3'b100
    } t_state;

    t_state        r_state, n_state;
    logic [IW-1:0] r_ptr, n_ptr;
    logic [IW-1:0] r_last, n_last;
    logic          r_first, n_first;

    // Next-state and pointer logic.
    always_comb begin
        n_state = r_state;
        n_ptr   = r_ptr;
        n_last  = r_last;
        n_first = r_first;
        unique case (r_state)
            S_IDLE: begin
                if (i_accept && (i_operation == OP_QUERY)) begin
                    n_ptr   = i_last;
                    n_last  = i_last;
                    n_first = 1'b1;
                    n_state = i_sts.empty ? S_DRAIN : S_WALK;
                end
            end
            S_WALK: begin
                if (r_first) begin
                    n_first = 1'b0;
                    n_ptr   = '0;
                end else if (r_ptr == r_last) begin
                    n_state = S_DRAIN;
                end else begin
                    n_ptr = r_ptr + IW'(1);
                end
            end
            S_DRAIN: begin
                if (!i_sts.busy && i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_first <= 1'b0;
        end else begin
            r_state <= n_state;
            r_first <= n_first;
        end
        r_ptr  <= n_ptr;
        r_last <= n_last;
    end

    // Commands to the datapath.
    always_comb begin
        o_cmd.append      = i_accept && (i_operation == OP_APPEND);
        o_cmd.query_start = i_accept && (i_operation == OP_QUERY);
        o_cmd.rd_en       = (r_state == S_WALK);
        o_cmd.rd_first    = r_first;
        o_cmd.load_out    = (r_state == S_DRAIN) && !i_sts.busy && i_sts.out_free;
    end

    assign o_rd_addr = r_ptr;
    assign o_busy    = (r_state != S_IDLE);

endmodule

FILE: hdl/pip_dp.sv
// ============================================================================
// Point-in-polygon datapath
// Vertex store, three-stage edge crossing pipeline, parity flag and the
// output register.
// ============================================================================
module pip_dp import pip_pkg::*; #(
    parameter int MAX_VERTICES = 8,
    parameter int COORD_WIDTH  = 20,
    parameter int IW           = 3
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  t_dp_cmd                       i_cmd,
    input  logic [IW-1:0]                 i_rd_addr,
    input  logic signed [COORD_WIDTH-1:0] i_coord_x,
    input  logic signed [COORD_WIDTH-1:0] i_coord_y,
    input  logic                          i_starts_polygon,
    input  logic                          i_out_stall,
    output t_dp_sts                       o_sts,
    output logic [IW-1:0]                 o_last,
    output logic                          o_out_valid,
    output logic                          o_inside_res,
    output logic                          o_vertex_overflow
);

    localparam int W  = COORD_WIDTH;
    localparam int CW = $clog2(MAX_VERTICES + 1);
    localparam int PW = 2 * W + 2;

    // Vertex store.
    logic [W-1:0] mem_x [MAX_VERTICES];
    logic [W-1:0] mem_y [MAX_VERTICES];

    logic [CW-1:0] r_count;
    logic          r_overflow;
    logic [CW-1:0] count_m1;
    logic          has_room;
    logic          wr_en;
    logic [IW-1:0] wr_addr;

    assign has_room = (r_count < CW'(MAX_VERTICES));
    assign wr_en    = i_cmd.append && (i_starts_polygon || has_room);
    assign wr_addr  = i_starts_polygon ? '0 : r_count[IW-1:0];
    assign count_m1 = r_count - CW'(1);
    assign o_last   = count_m1[IW-1:0];

    // Store writes on append.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_x[wr_addr] <= i_coord_x;
            mem_y[wr_addr] <= i_coord_y;
        end
    end

    // Fill count and overflow flag; a new polygon restarts both.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count    <= '0;
            r_overflow <= 1'b0;
        end else if (i_cmd.append) begin
            if (i_starts_polygon) begin
                r_count    <= CW'(1);
                r_overflow <= 1'b0;
            end else if (has_room) begin
                r_count <= r_count + CW'(1);
            end else begin
                r_overflow <= 1'b1;
            end
        end
    end

    // Registered store read.
    logic signed [W-1:0] r_rd_x, r_rd_y;
    logic                r_s1_vld, r_s1_first;

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_rd_x <= mem_x[i_rd_addr];
            r_rd_y <= mem_y[i_rd_addr];
        end
    end

    // Query point.
    logic signed [W-1:0] r_px, r_py;

    always_ff @(posedge i_clk) begin
        if (i_cmd.query_start) begin
            r_px <= i_coord_x;
            r_py <= i_coord_y;
        end
    end

    // Stage 1: differences and straddle test against the previous vertex.
    logic signed [W-1:0] r_prev_x, r_prev_y;
    logic signed [W:0]   r_lx, r_d, r_rx, r_ry;
    logic                r_s2_vld, r_s2_strad, r_s2_dpos;
    logic                above_i, above_j;
    logic signed [W:0]   d_diff;

    assign above_i = (r_rd_y > r_py);
    assign above_j = (r_prev_y > r_py);
    assign d_diff  = $signed({r_prev_y[W-1], r_prev_y}) - $signed({r_rd_y[W-1], r_rd_y});

    always_ff @(posedge i_clk) begin
        if (r_s1_vld) begin
            r_prev_x <= r_rd_x;
            r_prev_y <= r_rd_y;
        end
        if (r_s1_vld && !r_s1_first) begin
            r_lx       <= $signed({r_px[W-1], r_px}) - $signed({r_rd_x[W-1], r_rd_x});
            r_d        <= d_diff;
            r_rx       <= $signed({r_prev_x[W-1], r_prev_x}) - $signed({r_rd_x[W-1], r_rd_x});
            r_ry       <= $signed({r_py[W-1], r_py}) - $signed({r_rd_y[W-1], r_rd_y});
            r_s2_strad <= (above_i != above_j);
            r_s2_dpos  <= (d_diff > 0);
        end
    end

    // Stage 2: the two cross products.
    logic signed [PW-1:0] r_p1, r_p2;
    logic                 r_s3_vld, r_s3_strad, r_s3_dpos;

    always_ff @(posedge i_clk) begin
        if (r_s2_vld) begin
            r_p1       <= PW'(r_lx) * PW'(r_d);
            r_p2       <= PW'(r_rx) * PW'(r_ry);
            r_s3_strad <= r_s2_strad;
            r_s3_dpos  <= r_s2_dpos;
        end
    end

    // Stage 3: sign-corrected compare toggles the parity.
    logic r_inside;
    logic left;

    assign left = r_s3_dpos ? (r_p1 < r_p2) : (r_p2 < r_p1);

    always_ff @(posedge i_clk) begin
        if (i_cmd.query_start) begin
            r_inside <= 1'b0;
        end else if (r_s3_vld && r_s3_strad && left) begin
            r_inside <= ~r_inside;
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
        end else begin
            r_s1_vld <= i_cmd.rd_en;
            r_s2_vld <= r_s1_vld && !r_s1_first;
            r_s3_vld <= r_s2_vld;
        end
        r_s1_first <= i_cmd.rd_first;
    end

    // Output register; a waiting result does not block new work.
    logic r_out_vld, r_out_inside, r_out_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
        if (i_cmd.load_out) begin
            r_out_inside <= r_inside;
            r_out_ovf    <= r_overflow;
        end
    end

    assign o_out_valid       = r_out_vld;
    assign o_inside_res      = r_out_inside;
    assign o_vertex_overflow = r_out_ovf;

    // Status to the controller.
    always_comb begin
        o_sts.busy     = r_s1_vld || r_s2_vld || r_s3_vld;
        o_sts.out_free = !r_out_vld || !i_out_stall;
        o_sts.empty    = (r_count == '0);
    end

endmodule

FILE: hdl/point_in_polygon_test.sv
// ============================================================================
// Point-in-polygon test
// Stores one polygon and answers even-odd crossing-number point queries.
// ============================================================================
// An append item gives no result; the block is ready for the next item in
// the following cycle. A query holds the input stalled while the single-port
// vertex memory is read, once for the closing vertex and once per edge, and
// while the three-stage difference, multiply and compare pipeline drains;
// its result is then moved into the output register, as long as that
// register can take it. While an earlier result still waits under a stall,
// the query holds the input until that result moves on. An empty polygon
// skips the memory reads. A result waiting in the output register does not
// stall appends or the walk of the next query.
module point_in_polygon_test import pip_pkg::*; #(
    parameter int MAX_VERTICES = 8,
    parameter int COORD_WIDTH  = 20
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_operation,
    input  logic signed [COORD_WIDTH-1:0] i_coord_x,
    input  logic signed [COORD_WIDTH-1:0] i_coord_y,
    input  logic                          i_starts_polygon,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_inside_res,
    output logic                          o_vertex_overflow
);

`include "point_in_polygon_test_defines.svh"

    localparam int IW = $clog2(MAX_VERTICES);

    t_dp_cmd       cmd;
    t_dp_sts       sts;
    logic [IW-1:0] rd_addr;
    logic [IW-1:0] last_idx;
    logic          busy;
    logic          in_xfer;
    logic          query_xfer;
    logic          append_xfer;

    // Input transfer.
    assign o_in_stall  = busy;
    assign in_xfer     = i_in_valid && !busy;
    assign query_xfer  = in_xfer && (i_operation == OP_QUERY);
    assign append_xfer = in_xfer && (i_operation == OP_APPEND);

    // Controller.
    pip_ctrl #(
        .IW (IW)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_xfer),
        .i_operation (i_operation),
        .i_sts       (sts),
        .i_last      (last_idx),
        .o_cmd       (cmd),
        .o_rd_addr   (rd_addr),
        .o_busy      (busy)
    );

    // Datapath.
    pip_dp #(
        .MAX_VERTICES (MAX_VERTICES),
        .COORD_WIDTH  (COORD_WIDTH),
        .IW           (IW)
    ) u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_rd_addr         (rd_addr),
        .i_coord_x         (i_coord_x),
        .i_coord_y         (i_coord_y),
        .i_starts_polygon  (i_starts_polygon),
        .i_out_stall       (i_out_stall),
        .o_sts             (sts),
        .o_last            (last_idx),
        .o_out_valid       (o_out_valid),
        .o_inside_res      (o_inside_res),
        .o_vertex_overflow (o_vertex_overflow)
    );

    // A query transfer always starts a walk or a drain.
    `PIP_ASSERT_NEXT(a_query_busy, query_xfer, o_in_stall, "query did not start")

    // A result appears only at the end of a query.
    `PIP_ASSERT_NOW(a_result_from_query, $rose(o_out_valid), $past(o_in_stall), "stray result")

    // An append never creates a result.
    `PIP_ASSERT_NEXT(a_append_silent, append_xfer && !o_out_valid, !o_out_valid, "append result")

endmodule

FILE: tb/sv/tb.sv
// ============================================================================
// Point-in-polygon test bench
// Loads polygons vertex by vertex and checks every point query against an
// exact even-odd crossing predictor kept in step with each accepted transfer.
// ============================================================================
module tb;
    import pip_pkg::*;

    localparam int MAX_VERTICES   = 8;
    localparam int COORD_WIDTH    = 20;
    localparam int COORD_HALF     = 1 << (COORD_WIDTH - 1);
    localparam int COORD_MAX      = COORD_HALF - 1;
    localparam int COORD_MIN      = -COORD_HALF;
    localparam int ITEM_TARGET    = 1550;
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int DRAIN_CYCLES   = MAX_VERTICES + 12;

    typedef struct {
        logic                          op;
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic                          start;
        bit                            drain;   // wait for all answers before sending
    } t_poly_item;

    typedef struct {
        logic in_poly;
        logic overflow;
    } t_answer;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_in_valid = 1'b0;
    logic                          o_in_stall;
    logic                          i_operation = OP_APPEND;
    logic signed [COORD_WIDTH-1:0] i_coord_x = '0;
    logic signed [COORD_WIDTH-1:0] i_coord_y = '0;
    logic                          i_starts_polygon = 1'b0;
    logic                          o_out_valid;
    logic                          i_out_stall = 1'b0;
    logic                          o_inside_res;
    logic                          o_vertex_overflow;

    // Pending stimulus and the answers still owed by the block.
    t_poly_item item_q[$];
    t_answer    answer_q[$];
    t_poly_item cur_item;
    bit         in_taken = 1'b0;
    int         sent_cnt = 0;
    int         total_items = 1;
    int         cycle_cnt = 0;
    int         error_cnt = 0;

    // Predictor copy of the stored polygon.
    logic signed [COORD_WIDTH-1:0] poly_x[MAX_VERTICES];
    logic signed [COORD_WIDTH-1:0] poly_y[MAX_VERTICES];
    int                            poly_count = 0;
    logic                          poly_overflow = 1'b0;

    point_in_polygon_test #(
        .MAX_VERTICES(MAX_VERTICES),
        .COORD_WIDTH (COORD_WIDTH)
    ) DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_operation      (i_operation),
        .i_coord_x        (i_coord_x),
        .i_coord_y        (i_coord_y),
        .i_starts_polygon (i_starts_polygon),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_inside_res     (o_inside_res),
        .o_vertex_overflow(o_vertex_overflow)
    );

    // Even-odd crossing test with exact cross-multiplication in place of the
    // division. Products stay below 2^42, so 64-bit arithmetic is exact.
    function automatic logic point_inside(logic signed [COORD_WIDTH-1:0] px,
                                          logic signed [COORD_WIDTH-1:0] py);
        longint xi, yi, xj, yj, pxl, pyl, d, lx, rx, ry;
        logic   parity;
        logic   left;
        int     j;
        parity = 1'b0;
        if (poly_count == 0) begin
            return 1'b0;
        end
        pxl = px;
        pyl = py;
        j = poly_count - 1;
        for (int i = 0; i < poly_count; i++) begin
            xi = poly_x[i];
            yi = poly_y[i];
            xj = poly_x[j];
            yj = poly_y[j];
            if ((yi > pyl) != (yj > pyl)) begin
                d  = yj - yi;
                lx = pxl - xi;
                rx = xj - xi;
                ry = pyl - yi;
                if (d > 0) begin
                    left = (lx * d) < (rx * ry);
                end else begin
                    left = (rx * ry) < (lx * d);
                end
                parity ^= left;
            end
            j = i;
        end
        return parity;
    endfunction

    // Update the polygon on an append; queue the answer on a query.
    task automatic apply_item(input t_poly_item it);
        t_answer ans;
        if (it.op == OP_APPEND) begin
            if (it.start) begin
                poly_count    = 0;
                poly_overflow = 1'b0;
            end
            if (poly_count < MAX_VERTICES) begin
                poly_x[poly_count] = it.x;
                poly_y[poly_count] = it.y;
                poly_count++;
            end else begin
                poly_overflow = 1'b1;
            end
        end else begin
            ans.in_poly  = point_inside(it.x, it.y);
            ans.overflow = poly_overflow;
            answer_q = {answer_q, ans};
        end
    endtask

    task automatic add_item(logic op, int x, int y, logic start, bit drain);
        t_poly_item it;
        it.op    = op;
        it.x     = COORD_WIDTH'(x);
        it.y     = COORD_WIDTH'(y);
        it.start = start;
        it.drain = drain;
        item_q = {item_q, it};
    endtask

    // Uniform coordinate in [-span, span - 1]; span never exceeds half range.
    function automatic int rand_coord(int span);
        return int'($urandom_range(0, 2 * span - 1)) - span;
    endfunction

    // Clock.
    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Reset, released on a falling edge.
    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // Stimulus: a directed opening, then mostly well-formed polygons with
    // queries, mixed with free-running noise.
    initial begin
        logic signed [COORD_WIDTH-1:0] vx[12];
        logic signed [COORD_WIDTH-1:0] vy[12];
        int spans[4];
        int span, nv, nq, k, qx, qy;
        spans = '{16, 1024, 65536, COORD_HALF};

        // Empty polygon, and a start flag on a query that must be ignored.
        add_item(OP_QUERY, 0, 0, 1'b0, 1'b0);
        add_item(OP_QUERY, COORD_MAX, COORD_MIN, 1'b1, 1'b0);
        // A single vertex gives a degenerate edge.
        add_item(OP_APPEND, 0, 0, 1'b1, 1'b0);
        add_item(OP_QUERY, COORD_MIN, 0, 1'b0, 1'b0);
        // Two vertices: both edges straddle and cancel.
        add_item(OP_APPEND, 1000, 2000, 1'b0, 1'b0);
        add_item(OP_QUERY, -10, 1000, 1'b0, 1'b0);
        // Triangle spanning the full coordinate range.
        add_item(OP_APPEND, COORD_MIN, COORD_MIN, 1'b1, 1'b0);
        add_item(OP_APPEND, COORD_MAX, COORD_MIN, 1'b0, 1'b0);
        add_item(OP_APPEND, 0, COORD_MAX, 1'b0, 1'b0);
        add_item(OP_QUERY, 0, 0, 1'b0, 1'b0);
        add_item(OP_QUERY, COORD_MIN, COORD_MAX - 1, 1'b0, 1'b0);
        // Square with points exactly on the crossings and on a vertex level.
        add_item(OP_APPEND, 0, 0, 1'b1, 1'b0);
        add_item(OP_APPEND, 100, 0, 1'b0, 1'b0);
        add_item(OP_APPEND, 100, 100, 1'b0, 1'b0);
        add_item(OP_APPEND, 0, 100, 1'b0, 1'b0);
        add_item(OP_QUERY, 0, 50, 1'b0, 1'b0);
        add_item(OP_QUERY, 100, 50, 1'b0, 1'b0);
        add_item(OP_QUERY, 50, 0, 1'b0, 1'b0);
        // Fill the store past capacity; the last vertex is dropped.
        add_item(OP_APPEND, COORD_MAX, COORD_MAX, 1'b0, 1'b0);
        add_item(OP_APPEND, COORD_MIN, COORD_MAX, 1'b0, 1'b0);
        add_item(OP_APPEND, COORD_MAX, COORD_MIN, 1'b0, 1'b0);
        add_item(OP_APPEND, COORD_MIN, COORD_MIN, 1'b0, 1'b0);
        add_item(OP_APPEND, 1, -1, 1'b0, 1'b0);
        add_item(OP_QUERY, 50, 50, 1'b0, 1'b1);
        // A new polygon clears the overflow flag.
        add_item(OP_APPEND, 0, 0, 1'b1, 1'b0);
        add_item(OP_QUERY, 0, 0, 1'b0, 1'b0);

        while (item_q.size() < ITEM_TARGET) begin
            if ($urandom_range(0, 99) < 15) begin
                add_item(1'($urandom_range(0, 1)), rand_coord(COORD_HALF),
                         rand_coord(COORD_HALF), 1'($urandom_range(0, 1)), 1'b0);
            end else begin
                span = spans[$urandom_range(0, 3)];
                nv = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 11)
                                                 : $urandom_range(1, 8);
                for (k = 0; k < nv; k++) begin
                    vx[k] = COORD_WIDTH'(rand_coord(span));
                    vy[k] = COORD_WIDTH'(rand_coord(span));
                    add_item(OP_APPEND, int'(vx[k]), int'(vy[k]), k == 0,
                             (k == 0) && ($urandom_range(0, 49) == 0));
                end
                nq = $urandom_range(1, 6);
                for (int q = 0; q < nq; q++) begin
                    k = $urandom_range(0, nv - 1);
                    case ($urandom_range(0, 3))
                        0: begin
                            qx = rand_coord(span);
                            qy = int'(vy[k]);
                        end
                        1: begin
                            qx = int'(vx[k]);
                            qy = int'(vy[k]);
                        end
                        default: begin
                            qx = rand_coord(span);
                            qy = rand_coord(span);
                        end
                    endcase
                    add_item(OP_QUERY, qx, qy, 1'($urandom_range(0, 1)), 1'b0);
                end
            end
        end
        total_items = item_q.size();
    end

    // Driver: present the next item once the current one has transferred.
    always @(negedge i_clk) begin
        int  phase;
        int  send_idle;
        int  recv_idle;
        bit  load;
        phase = (sent_cnt * 3) / total_items;
        send_idle = (phase == 0) ? 12 : (phase == 1) ? 84 : 0;
        recv_idle = (phase == 0) ? 84 : (phase == 1) ? 12 : 0;
        load = in_taken || !i_in_valid;
        in_taken = 1'b0;
        if (!i_rst_n) begin
            i_in_valid  <= 1'b0;
            i_out_stall <= 1'b0;
        end else begin
            i_out_stall <= ($urandom_range(0, 99) < recv_idle);
            if (load) begin
                if (item_q.size() == 0 || (item_q[0].drain && answer_q.size() != 0) ||
                    $urandom_range(0, 99) < send_idle) begin
                    i_in_valid <= 1'b0;
                end else begin
                    cur_item = item_q.pop_front();
                    i_in_valid       <= 1'b1;
                    i_operation      <= cur_item.op;
                    i_coord_x        <= cur_item.x;
                    i_coord_y        <= cur_item.y;
                    i_starts_polygon <= cur_item.start;
                end
            end
        end
    end

    // Monitor: check each result transfer, then predict from each input one.
    always @(posedge i_clk) begin
        t_answer exp_ans;
        cycle_cnt++;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (answer_q.size() == 0) begin
                $display("%0t: result transfer with no answer pending", $time);
                error_cnt++;
            end else begin
                exp_ans = answer_q.pop_front();
                if (o_inside_res !== exp_ans.in_poly) begin
                    $display("%0t: inside_res expected %0b actual %0b",
                             $time, exp_ans.in_poly, o_inside_res);
                    error_cnt++;
                end
                if (o_vertex_overflow !== exp_ans.overflow) begin
                    $display("%0t: vertex_overflow expected %0b actual %0b",
                             $time, exp_ans.overflow, o_vertex_overflow);
                    error_cnt++;
                end
            end
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            apply_item(cur_item);
            sent_cnt++;
            in_taken = 1'b1;
        end
    end

    // End of run: all items sent, all answers in, then a short quiet spell.
    initial begin
        @(posedge i_rst_n);
        @(posedge i_clk);
        while (item_q.size() != 0 || i_in_valid) @(posedge i_clk);
        while (answer_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_cnt == 0 && answer_q.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        wait (cycle_cnt >= TIMEOUT_CYCLES);
        $display("%0t: run did not finish in time", $time);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

FILE: point_in_polygon_test.f
+incdir+hdl
hdl/pip_pkg.sv
hdl/pip_ctrl.sv
hdl/pip_dp.sv
hdl/point_in_polygon_test.sv
tb/sv/tb.sv
